// ===== hdl/bpm_pkg.sv =====
// Package with types, constants and codes shared by the power manager files.
`default_nettype none
package bpm_pkg;

    localparam int unsigned MV_W    = 16;
    localparam int unsigned PCT_W   = 7;
    localparam int unsigned MS_W    = 32;
    localparam int unsigned LVL_W   = 8;
    localparam int unsigned NUM_W   = 23;
    localparam int unsigned STEP_W  = 3;
    localparam int unsigned ADDR_W  = 5;
    localparam int unsigned DATA_W  = 32;

    localparam logic [MV_W-1:0]  CHARGE_MV = 16'd4250;
    localparam logic [PCT_W:0]   HYST_PCT  = 8'd5;
    localparam logic [PCT_W-1:0] FULL_PCT  = 7'd100;

    localparam logic [1:0] KIND_BATT = 2'd0;
    localparam logic [1:0] KIND_IDLE = 2'd1;
    localparam logic [1:0] KIND_WAKE = 2'd2;

    localparam logic [2:0] REG_BRIGHTNESS = 3'd0;
    localparam logic [2:0] REG_DIM_BRIGHT = 3'd1;
    localparam logic [2:0] REG_DIM_AFTER  = 3'd2;
    localparam logic [2:0] REG_OFF_AFTER  = 3'd3;
    localparam logic [2:0] REG_WARN_PCT   = 3'd4;
    localparam logic [2:0] REG_EMPTY_MV   = 3'd5;
    localparam logic [2:0] REG_FULL_MV    = 3'd6;

    localparam logic [LVL_W-1:0] RST_BRIGHTNESS = 8'd200;
    localparam logic [LVL_W-1:0] RST_DIM_BRIGHT = 8'd25;
    localparam logic [MS_W-1:0]  RST_DIM_AFTER  = 32'd20000;
    localparam logic [MS_W-1:0]  RST_OFF_AFTER  = 32'd60000;
    localparam logic [PCT_W-1:0] RST_WARN_PCT   = 7'd15;
    localparam logic [MV_W-1:0]  RST_EMPTY_MV   = 16'd3300;
    localparam logic [MV_W-1:0]  RST_FULL_MV    = 16'd4200;

    typedef struct packed {
        logic [LVL_W-1:0] brightness;
        logic [LVL_W-1:0] dim_bright;
        logic [MS_W-1:0]  dim_after_ms;
        logic [MS_W-1:0]  off_after_ms;
        logic [PCT_W-1:0] warn_percent;
        logic [MV_W-1:0]  empty_mv;
        logic [MV_W-1:0]  full_mv;
    } t_cfg;

    typedef struct packed {
        logic [1:0]      kind;
        logic [MV_W-1:0] reading_mv;
        logic [MS_W-1:0] idle_ms;
    } t_req;

    typedef struct packed {
        logic [MV_W-1:0]  battery_mv;
        logic [PCT_W-1:0] percent;
        logic             charging;
        logic             low_warn;
        logic             low_warn_new;
        logic             screen_on;
        logic             dimmed;
        logic [LVL_W-1:0] drive_level;
        logic             sleep_now;
        logic             wake_now;
    } t_rsp;

    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] num;
        logic [MV_W-1:0]  den;
    } t_div_cmd;

    typedef struct packed {
        logic             done;
        logic [PCT_W-1:0] quot;
    } t_div_res;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UPD,
        ST_PREP,
        ST_START,
        ST_WAIT,
        ST_FIN,
        ST_OUT
    } t_state;

    typedef enum logic [1:0] {
        PCT_ZERO,
        PCT_FULL,
        PCT_DIV
    } t_pct_src;

endpackage
`default_nettype wire

// ===== hdl/bpm_req_if.sv =====
// Request channel interface carrying one power manager input item.
`default_nettype none
interface bpm_req_if;
    logic           valid;
    logic           ready;
    bpm_pkg::t_req  payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ===== hdl/bpm_rsp_if.sv =====
// Result channel interface carrying one power manager status item.
`default_nettype none
interface bpm_rsp_if;
    logic           valid;
    logic           ready;
    bpm_pkg::t_rsp  payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ===== hdl/bpm_cfg.sv =====
// APB configuration register bank of the power manager.
`default_nettype none
module bpm_cfg (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [bpm_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [bpm_pkg::DATA_W-1:0]  pwdata,
    output logic      [bpm_pkg::DATA_W-1:0]  prdata,
    output logic                             pready,
    output bpm_pkg::t_cfg                    o_cfg
);

    bpm_pkg::t_cfg r_cfg;
    logic [2:0]    w_idx;
    logic          w_wr;

    assign w_idx  = paddr[bpm_pkg::ADDR_W-1:2];
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.brightness   <= bpm_pkg::RST_BRIGHTNESS;
            r_cfg.dim_bright   <= bpm_pkg::RST_DIM_BRIGHT;
            r_cfg.dim_after_ms <= bpm_pkg::RST_DIM_AFTER;
            r_cfg.off_after_ms <= bpm_pkg::RST_OFF_AFTER;
            r_cfg.warn_percent <= bpm_pkg::RST_WARN_PCT;
            r_cfg.empty_mv     <= bpm_pkg::RST_EMPTY_MV;
            r_cfg.full_mv      <= bpm_pkg::RST_FULL_MV;
        end else if (w_wr) begin
            unique case (w_idx)
                bpm_pkg::REG_BRIGHTNESS: r_cfg.brightness   <= pwdata[7:0];
                bpm_pkg::REG_DIM_BRIGHT: r_cfg.dim_bright   <= pwdata[7:0];
                bpm_pkg::REG_DIM_AFTER:  r_cfg.dim_after_ms <= pwdata;
                bpm_pkg::REG_OFF_AFTER:  r_cfg.off_after_ms <= pwdata;
                bpm_pkg::REG_WARN_PCT:   r_cfg.warn_percent <= pwdata[6:0];
                bpm_pkg::REG_EMPTY_MV:   r_cfg.empty_mv     <= pwdata[15:0];
                bpm_pkg::REG_FULL_MV:    r_cfg.full_mv      <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            bpm_pkg::REG_BRIGHTNESS: prdata = {24'd0, r_cfg.brightness};
            bpm_pkg::REG_DIM_BRIGHT: prdata = {24'd0, r_cfg.dim_bright};
            bpm_pkg::REG_DIM_AFTER:  prdata = r_cfg.dim_after_ms;
            bpm_pkg::REG_OFF_AFTER:  prdata = r_cfg.off_after_ms;
            bpm_pkg::REG_WARN_PCT:   prdata = {25'd0, r_cfg.warn_percent};
            bpm_pkg::REG_EMPTY_MV:   prdata = {16'd0, r_cfg.empty_mv};
            bpm_pkg::REG_FULL_MV:    prdata = {16'd0, r_cfg.full_mv};
            default:                 prdata = '0;
        endcase
    end

endmodule
`default_nettype wire

// ===== hdl/bpm_div.sv =====
// Restoring divider that produces the seven-bit charge percentage one bit per cycle.
`default_nettype none
module bpm_div (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire bpm_pkg::t_div_cmd i_cmd,
    output bpm_pkg::t_div_res o_res
);

    logic                              r_busy;
    logic                              r_done;
    logic [bpm_pkg::STEP_W-1:0]        r_cnt;
    logic [bpm_pkg::NUM_W-1:0]         r_rem;
    logic [bpm_pkg::NUM_W-1:0]         r_dsh;
    logic [bpm_pkg::PCT_W-1:0]         r_quot;
    logic                              w_fit;

    assign w_fit      = r_rem >= r_dsh;
    assign o_res.done = r_done;
    assign o_res.quot = r_quot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_cmd.start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= 3'(bpm_pkg::PCT_W - 1);
        end else if (r_busy) begin
            r_cnt  <= r_cnt - 3'd1;
            r_busy <= (r_cnt != '0);
            r_done <= (r_cnt == '0);
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_rem  <= i_cmd.num;
            r_dsh  <= {1'b0, i_cmd.den, 6'd0};
            r_quot <= '0;
        end else if (r_busy) begin
            r_rem  <= w_fit ? (r_rem - r_dsh) : r_rem;
            r_dsh  <= r_dsh >> 1;
            r_quot <= {r_quot[bpm_pkg::PCT_W-2:0], w_fit};
        end
    end

endmodule
`default_nettype wire

// ===== hdl/battery_and_screen_power_manager_unit.sv =====
// Top level of the battery and screen power manager with its item sequencer.
// Sequence: an accepted request passes through the update and prep states, then
// through start and wait while the seven steps of the restoring divider run when
// the percentage lies strictly between empty and full, then through fin and out.
// Handshake: one request at a time; a new request can be accepted in the cycle
// after the result is taken.
// Reset: synchronous active low; registers return to their defaults, battery value
// to zero, screen on and undimmed, warning cleared.
`default_nettype none
module battery_and_screen_power_manager_unit (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    bpm_req_if.sink                          i_req,
    bpm_rsp_if.source                        o_rsp,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [bpm_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [bpm_pkg::DATA_W-1:0]  pwdata,
    output logic      [bpm_pkg::DATA_W-1:0]  prdata,
    output logic                             pready
);

    bpm_pkg::t_cfg     w_cfg;
    bpm_pkg::t_div_cmd w_div_cmd;
    bpm_pkg::t_div_res w_div_res;

    bpm_pkg::t_state   r_state;
    bpm_pkg::t_state   n_state;
    bpm_pkg::t_req     r_item;
    bpm_pkg::t_rsp     r_rsp;
    bpm_pkg::t_pct_src r_sel;
    bpm_pkg::t_pct_src n_sel;

    logic [bpm_pkg::MV_W-1:0]  r_mv;
    logic                      r_screen;
    logic                      r_dim;
    logic                      r_warn;
    logic                      r_sleep;
    logic                      r_wake;
    logic [bpm_pkg::MV_W-1:0]  r_diff;
    logic [bpm_pkg::MV_W-1:0]  r_span;

    logic [bpm_pkg::MV_W+1:0]  w_sum;
    logic [bpm_pkg::MV_W-1:0]  n_mv;
    logic                      n_screen;
    logic                      n_dim;
    logic                      n_sleep;
    logic                      n_wake;
    logic                      w_off_hit;
    logic                      w_dim_hit;
    logic [bpm_pkg::NUM_W-1:0] w_diff_x;
    logic [bpm_pkg::PCT_W-1:0] w_pct;
    logic                      w_charging;
    logic                      n_warn;
    logic                      n_warn_new;
    logic                      w_accept;

    bpm_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    bpm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_div_cmd),
        .o_res   (w_div_res)
    );

    assign w_accept = i_req.valid && i_req.ready;

    // Battery smoothing and screen timeouts.
    assign w_sum     = ({2'b00, r_mv} << 1) + {2'b00, r_mv} + {2'b00, r_item.reading_mv};
    assign w_off_hit = (w_cfg.off_after_ms != '0) && (r_item.idle_ms > w_cfg.off_after_ms);
    assign w_dim_hit = (w_cfg.dim_after_ms != '0) && (r_item.idle_ms > w_cfg.dim_after_ms);

    always_comb begin
        n_mv     = r_mv;
        n_screen = r_screen;
        n_dim    = r_dim;
        n_sleep  = 1'b0;
        n_wake   = 1'b0;
        unique case (r_item.kind)
            bpm_pkg::KIND_BATT: begin
                n_mv = (r_mv == '0) ? r_item.reading_mv : w_sum[bpm_pkg::MV_W+1:2];
            end
            bpm_pkg::KIND_IDLE: begin
                if (w_off_hit) begin
                    n_screen = 1'b0;
                    n_sleep  = r_screen;
                end else if (w_dim_hit) begin
                    n_dim = r_dim || r_screen;
                end else begin
                    n_screen = 1'b1;
                    n_wake   = !r_screen;
                    n_dim    = 1'b0;
                end
            end
            bpm_pkg::KIND_WAKE: begin
                n_screen = 1'b1;
                n_wake   = !r_screen;
                n_dim    = 1'b0;
            end
            default: ;
        endcase
    end

    // Percentage source selection and divider operands.
    always_comb begin
        if (r_mv <= w_cfg.empty_mv) begin
            n_sel = bpm_pkg::PCT_ZERO;
        end else if (r_mv >= w_cfg.full_mv) begin
            n_sel = bpm_pkg::PCT_FULL;
        end else begin
            n_sel = bpm_pkg::PCT_DIV;
        end
    end

    assign w_diff_x        = {7'd0, r_diff};
    assign w_div_cmd.start = (r_state == bpm_pkg::ST_START);
    assign w_div_cmd.num   = (w_diff_x << 6) + (w_diff_x << 5) + (w_diff_x << 2);
    assign w_div_cmd.den   = r_span;

    always_comb begin
        unique case (r_sel)
            bpm_pkg::PCT_ZERO: w_pct = '0;
            bpm_pkg::PCT_FULL: w_pct = bpm_pkg::FULL_PCT;
            bpm_pkg::PCT_DIV:  w_pct = w_div_res.quot;
            default:           w_pct = '0;
        endcase
    end

    assign w_charging = r_mv > bpm_pkg::CHARGE_MV;

    always_comb begin
        n_warn     = r_warn;
        n_warn_new = 1'b0;
        if (r_item.kind == bpm_pkg::KIND_BATT) begin
            if ((w_pct <= w_cfg.warn_percent) && !w_charging) begin
                n_warn     = 1'b1;
                n_warn_new = !r_warn;
            end else if ({1'b0, w_pct} > ({1'b0, w_cfg.warn_percent} + bpm_pkg::HYST_PCT)) begin
                n_warn = 1'b0;
            end
        end
    end

    // Sequencer next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            bpm_pkg::ST_IDLE:  if (i_req.valid) n_state = bpm_pkg::ST_UPD;
            bpm_pkg::ST_UPD:   n_state = bpm_pkg::ST_PREP;
            bpm_pkg::ST_PREP: begin
                n_state = (n_sel == bpm_pkg::PCT_DIV) ? bpm_pkg::ST_START : bpm_pkg::ST_FIN;
            end
            bpm_pkg::ST_START: n_state = bpm_pkg::ST_WAIT;
            bpm_pkg::ST_WAIT:  if (w_div_res.done) n_state = bpm_pkg::ST_FIN;
            bpm_pkg::ST_FIN:   n_state = bpm_pkg::ST_OUT;
            bpm_pkg::ST_OUT:   if (o_rsp.ready) n_state = bpm_pkg::ST_IDLE;
            default:           n_state = bpm_pkg::ST_IDLE;
        endcase
    end

    // Sequencer outputs.
    always_comb begin
        i_req.ready   = (r_state == bpm_pkg::ST_IDLE);
        o_rsp.valid   = (r_state == bpm_pkg::ST_OUT);
        o_rsp.payload = r_rsp;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= bpm_pkg::ST_IDLE;
            r_mv     <= '0;
            r_screen <= 1'b1;
            r_dim    <= 1'b0;
            r_warn   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == bpm_pkg::ST_UPD) begin
                r_mv     <= n_mv;
                r_screen <= n_screen;
                r_dim    <= n_dim;
            end
            if (r_state == bpm_pkg::ST_FIN) begin
                r_warn <= n_warn;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item <= i_req.payload;
        end
        if (r_state == bpm_pkg::ST_UPD) begin
            r_sleep <= n_sleep;
            r_wake  <= n_wake;
        end
        if (r_state == bpm_pkg::ST_PREP) begin
            r_sel  <= n_sel;
            r_diff <= r_mv - w_cfg.empty_mv;
            r_span <= w_cfg.full_mv - w_cfg.empty_mv;
        end
        if (r_state == bpm_pkg::ST_FIN) begin
            r_rsp.battery_mv   <= r_mv;
            r_rsp.percent      <= w_pct;
            r_rsp.charging     <= w_charging;
            r_rsp.low_warn     <= n_warn;
            r_rsp.low_warn_new <= n_warn_new;
            r_rsp.screen_on    <= r_screen;
            r_rsp.dimmed       <= r_dim;
            r_rsp.drive_level  <= r_dim ? w_cfg.dim_bright : w_cfg.brightness;
            r_rsp.sleep_now    <= r_sleep;
            r_rsp.wake_now     <= r_wake;
        end
    end

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> !i_req.ready)
        else $error("request accepted while an item is in progress");

    a_percent_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid |-> (o_rsp.payload.percent <= bpm_pkg::FULL_PCT))
        else $error("percentage above full");

    a_dim_drive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.payload.dimmed) |->
            (o_rsp.payload.drive_level == w_cfg.dim_bright))
        else $error("dimmed result does not drive the dim level");

    a_sleep_wake: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid |-> !(o_rsp.payload.sleep_now && o_rsp.payload.wake_now))
        else $error("screen reported as both sleeping and waking");

endmodule
`default_nettype wire

// ===== test/tb.sv =====
// Self-checking testbench for the battery and screen power manager unit.
`default_nettype none
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import bpm_pkg::*;

    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam int NUM_REGS = 7;
    localparam int PHASES = 10;
    localparam int ITEMS_PER_PHASE = 125;
    localparam int DRAIN_CYCLES = 20;
    localparam int STALL_LIMIT = 2000;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic pready;

    bpm_req_if req_ch ();
    bpm_rsp_if rsp_ch ();

    battery_and_screen_power_manager_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    t_cfg cfg;
    logic [MV_W-1:0] batt_mv;
    logic scr_on;
    logic dimmed;
    logic warned;

    t_req item_backlog[$];
    t_rsp expected_status[$];
    int unsigned fail_count = 0;
    logic req_taken = 1'b0;
    int gap_left = 0;
    int burst_left = 0;
    logic [15:0] ready_mask = 16'hFFFF;
    logic [3:0] ready_step = '0;
    int idle_cycles = 0;
    int level_mv = -1;

    always #4 i_clk = ~i_clk;

    function automatic logic [PCT_W-1:0] charge_pct(input logic [MV_W-1:0] mv);
        if (mv <= cfg.empty_mv) return '0;
        if (mv >= cfg.full_mv) return FULL_PCT;
        return PCT_W'((32'(mv - cfg.empty_mv) * 100) / 32'(cfg.full_mv - cfg.empty_mv));
    endfunction

    function automatic t_rsp advance_power_state(input t_req r);
        t_rsp s;
        int unsigned blend;
        logic [PCT_W-1:0] pct;
        s = '0;
        case (r.kind)
            KIND_BATT: begin
                if (batt_mv == '0) begin
                    batt_mv = r.reading_mv;
                end else begin
                    blend = 32'(batt_mv) * 3 + 32'(r.reading_mv);
                    batt_mv = MV_W'(blend / 4);
                end
                pct = charge_pct(batt_mv);
                if (pct <= cfg.warn_percent && batt_mv <= CHARGE_MV) begin
                    if (!warned) begin
                        warned = 1'b1;
                        s.low_warn_new = 1'b1;
                    end
                end else if (int'(pct) > int'(cfg.warn_percent) + int'(HYST_PCT)) begin
                    warned = 1'b0;
                end
            end
            KIND_IDLE: begin
                if (cfg.off_after_ms != '0 && r.idle_ms > cfg.off_after_ms) begin
                    if (scr_on) begin
                        scr_on = 1'b0;
                        s.sleep_now = 1'b1;
                    end
                end else if (cfg.dim_after_ms != '0 && r.idle_ms > cfg.dim_after_ms) begin
                    if (scr_on) dimmed = 1'b1;
                end else begin
                    if (!scr_on) begin
                        scr_on = 1'b1;
                        s.wake_now = 1'b1;
                    end
                    dimmed = 1'b0;
                end
            end
            KIND_WAKE: begin
                if (!scr_on) begin
                    scr_on = 1'b1;
                    s.wake_now = 1'b1;
                end
                dimmed = 1'b0;
            end
            default: begin
            end
        endcase
        s.battery_mv = batt_mv;
        s.percent = charge_pct(batt_mv);
        s.charging = (batt_mv > CHARGE_MV);
        s.low_warn = warned;
        s.screen_on = scr_on;
        s.dimmed = dimmed;
        s.drive_level = dimmed ? cfg.dim_bright : cfg.brightness;
        return s;
    endfunction

    function automatic logic [DATA_W-1:0] cfg_image(input int idx);
        case (3'(idx))
            REG_BRIGHTNESS: return DATA_W'(cfg.brightness);
            REG_DIM_BRIGHT: return DATA_W'(cfg.dim_bright);
            REG_DIM_AFTER:  return DATA_W'(cfg.dim_after_ms);
            REG_OFF_AFTER:  return DATA_W'(cfg.off_after_ms);
            REG_WARN_PCT:   return DATA_W'(cfg.warn_percent);
            REG_EMPTY_MV:   return DATA_W'(cfg.empty_mv);
            default:        return DATA_W'(cfg.full_mv);
        endcase
    endfunction

    function automatic t_req req_item(input logic [1:0] k, input logic [MV_W-1:0] mv,
                                      input logic [MS_W-1:0] ms);
        t_req it;
        it.kind = k;
        it.reading_mv = mv;
        it.idle_ms = ms;
        return it;
    endfunction

    function automatic logic [MS_W-1:0] pick_timeout();
        if ($urandom_range(0, 9) == 0) return '0;
        return MS_W'($urandom_range(1, 100000));
    endfunction

    function automatic t_cfg phase_config(input int ph);
        t_cfg c;
        c.brightness = LVL_W'($urandom);
        c.dim_bright = LVL_W'($urandom);
        c.dim_after_ms = pick_timeout();
        c.off_after_ms = pick_timeout();
        c.warn_percent = PCT_W'($urandom_range(0, 100));
        if ($urandom_range(0, 6) == 0) begin
            c.empty_mv = MV_W'($urandom_range(0, 65534));
            c.full_mv = MV_W'($urandom_range(int'(c.empty_mv) + 1, 65535));
        end else begin
            c.empty_mv = MV_W'($urandom_range(2500, 3600));
            c.full_mv = c.empty_mv + MV_W'($urandom_range(1, 1500));
        end
        case (ph)
            0: c = '{brightness: '0, dim_bright: '1, dim_after_ms: '0, off_after_ms: '0,
                     warn_percent: FULL_PCT, empty_mv: '0, full_mv: '1};
            1: c = '{brightness: '1, dim_bright: '0, dim_after_ms: '1, off_after_ms: '1,
                     warn_percent: '0, empty_mv: 16'd65534, full_mv: '1};
            2: begin
                c.empty_mv = MV_W'($urandom_range(3000, 4500));
                c.full_mv = c.empty_mv;
            end
            3: begin
                c.empty_mv = 16'd65534;
                c.full_mv = 16'd1;
            end
            4: c = '{brightness: RST_BRIGHTNESS, dim_bright: RST_DIM_BRIGHT,
                     dim_after_ms: RST_DIM_AFTER, off_after_ms: RST_OFF_AFTER,
                     warn_percent: RST_WARN_PCT, empty_mv: RST_EMPTY_MV, full_mv: RST_FULL_MV};
            default: begin
            end
        endcase
        return c;
    endfunction

    function automatic t_req make_item();
        t_req it;
        int lo;
        int hi;
        int sel;
        int mv;
        it.kind = KIND_UNUSED;
        it.reading_mv = MV_W'($urandom);
        it.idle_ms = $urandom;
        sel = $urandom_range(0, 99);
        if (sel < 40) begin
            it.kind = KIND_BATT;
            if (cfg.full_mv > cfg.empty_mv) begin
                lo = int'(cfg.empty_mv) - 300;
                hi = int'(cfg.full_mv) + 400;
            end else begin
                lo = int'(cfg.empty_mv) - 500;
                hi = int'(cfg.empty_mv) + 500;
            end
            if (lo < 0) lo = 0;
            if (hi > 65535) hi = 65535;
            sel = $urandom_range(0, 99);
            if (sel < 8) begin
            end else if (sel < 11) begin
                it.reading_mv = '0;
            end else if (sel < 16) begin
                it.reading_mv = MV_W'($urandom_range(4200, 4300));
            end else begin
                if (sel < 24 || level_mv < lo || level_mv > hi) begin
                    level_mv = $urandom_range(lo, hi);
                end else begin
                    level_mv = level_mv + int'($urandom_range(0, 200)) - 100;
                end
                if (level_mv < lo) level_mv = lo;
                if (level_mv > hi) level_mv = hi;
                mv = level_mv + int'($urandom_range(0, 40)) - 20;
                if (mv < 0) mv = 0;
                if (mv > 65535) mv = 65535;
                it.reading_mv = MV_W'(mv);
            end
        end else if (sel < 80) begin
            it.kind = KIND_IDLE;
            case ($urandom_range(0, 6))
                0: it.idle_ms = $urandom_range(0, cfg.dim_after_ms);
                1: it.idle_ms = cfg.dim_after_ms + MS_W'($urandom_range(0, 2)) - 1;
                2: it.idle_ms = $urandom_range(cfg.dim_after_ms, cfg.off_after_ms);
                3: it.idle_ms = cfg.off_after_ms + MS_W'($urandom_range(0, 2)) - 1;
                4: it.idle_ms = cfg.off_after_ms + MS_W'($urandom_range(0, 100000));
                5: it.idle_ms = $urandom_range(0, 1) ? '1 : '0;
                default: begin
                end
            endcase
        end else if (sel < 95) begin
            it.kind = KIND_WAKE;
        end
        return it;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    task automatic apb_access(input int idx, input logic wr, input logic [DATA_W-1:0] wdata,
                              output logic [DATA_W-1:0] rdata);
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= ADDR_W'(idx * 4);
        pwdata <= wdata;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic verify_regs();
        logic [DATA_W-1:0] rd;
        for (int i = 0; i < NUM_REGS; i++) begin
            apb_access(i, 1'b0, '0, rd);
            check_field($sformatf("register %0d", i), cfg_image(i), rd);
        end
    endtask

    task automatic apply_config(input t_cfg c);
        logic [DATA_W-1:0] rd;
        cfg = c;
        for (int i = 0; i < NUM_REGS; i++) begin
            apb_access(i, 1'b1, cfg_image(i), rd);
        end
        verify_regs();
    endtask

    task automatic wait_drained();
        while (item_backlog.size() != 0 || req_ch.valid || expected_status.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    // Request driver: bursts of random length separated by random gaps.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            req_ch.valid <= 1'b0;
        end else if (!req_ch.valid || req_taken) begin
            if (gap_left != 0) begin
                req_ch.valid <= 1'b0;
                gap_left = gap_left - 1;
            end else if (item_backlog.size() != 0) begin
                req_ch.payload <= item_backlog.pop_front();
                req_ch.valid <= 1'b1;
                if (burst_left <= 1) begin
                    burst_left = $urandom_range(1, 16);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 24);
                end else begin
                    burst_left = burst_left - 1;
                end
            end else begin
                req_ch.valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        rsp_ch.ready <= ready_mask[ready_step];
        ready_step <= ready_step + 4'd1;
    end

    always @(posedge i_clk) begin
        req_taken <= i_rst_n && req_ch.valid && req_ch.ready;
        if (i_rst_n && req_ch.valid && req_ch.ready) begin
            expected_status.push_back(advance_power_state(req_ch.payload));
        end
    end

    always @(posedge i_clk) begin : status_check
        t_rsp want;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (expected_status.size() == 0) begin
                $error("status result with no request waiting");
                fail_count++;
            end else begin
                want = expected_status.pop_front();
                check_field("battery_mv", want.battery_mv, rsp_ch.payload.battery_mv);
                check_field("percent", want.percent, rsp_ch.payload.percent);
                check_field("charging", want.charging, rsp_ch.payload.charging);
                check_field("low_warn", want.low_warn, rsp_ch.payload.low_warn);
                check_field("low_warn_new", want.low_warn_new, rsp_ch.payload.low_warn_new);
                check_field("screen_on", want.screen_on, rsp_ch.payload.screen_on);
                check_field("dimmed", want.dimmed, rsp_ch.payload.dimmed);
                check_field("drive_level", want.drive_level, rsp_ch.payload.drive_level);
                check_field("sleep_now", want.sleep_now, rsp_ch.payload.sleep_now);
                check_field("wake_now", want.wake_now, rsp_ch.payload.wake_now);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
            || (psel && penable && pready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("battery_and_screen_power_manager_unit regression: fail");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        t_cfg c;
        i_rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        req_ch.valid = 1'b0;
        req_ch.payload = '0;
        rsp_ch.ready = 1'b0;
        cfg = '{brightness: RST_BRIGHTNESS, dim_bright: RST_DIM_BRIGHT,
                dim_after_ms: RST_DIM_AFTER, off_after_ms: RST_OFF_AFTER,
                warn_percent: RST_WARN_PCT, empty_mv: RST_EMPTY_MV, full_mv: RST_FULL_MV};
        batt_mv = '0;
        scr_on = 1'b1;
        dimmed = 1'b0;
        warned = 1'b0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        verify_regs();
        @(posedge i_clk);

        // Smoothing restart on zero, warning raise, hold and release, then the
        // screen timeouts, wake from off and the unused kind.
        item_backlog.push_back(req_item(KIND_WAKE, 16'd0, 32'd0));
        item_backlog.push_back(req_item(KIND_UNUSED, '1, '1));
        item_backlog.push_back(req_item(KIND_BATT, 16'd0, '1));
        item_backlog.push_back(req_item(KIND_BATT, 16'd1, 32'd0));
        item_backlog.push_back(req_item(KIND_BATT, 16'd0, 32'd0));
        item_backlog.push_back(req_item(KIND_BATT, 16'd3700, 32'd0));
        item_backlog.push_back(req_item(KIND_BATT, 16'd3000, 32'd0));
        item_backlog.push_back(req_item(KIND_BATT, 16'd3300, 32'd0));
        item_backlog.push_back(req_item(KIND_BATT, 16'd3300, 32'd0));
        item_backlog.push_back(req_item(KIND_BATT, 16'd3300, 32'd0));
        item_backlog.push_back(req_item(KIND_BATT, 16'd3600, 32'd0));
        item_backlog.push_back(req_item(KIND_BATT, 16'd4000, 32'd0));
        item_backlog.push_back(req_item(KIND_BATT, '1, 32'd0));
        item_backlog.push_back(req_item(KIND_BATT, 16'd0, 32'd0));
        item_backlog.push_back(req_item(KIND_IDLE, '1, 32'd0));
        item_backlog.push_back(req_item(KIND_IDLE, 16'd0, 32'd20000));
        item_backlog.push_back(req_item(KIND_IDLE, 16'd0, 32'd20001));
        item_backlog.push_back(req_item(KIND_IDLE, 16'd0, 32'd60000));
        item_backlog.push_back(req_item(KIND_IDLE, 16'd0, 32'd60001));
        item_backlog.push_back(req_item(KIND_IDLE, 16'd0, '1));
        item_backlog.push_back(req_item(KIND_IDLE, 16'd0, 32'd30000));
        item_backlog.push_back(req_item(KIND_WAKE, '1, '1));
        item_backlog.push_back(req_item(KIND_IDLE, 16'd0, 32'd60001));
        item_backlog.push_back(req_item(KIND_IDLE, 16'd0, 32'd5));
        item_backlog.push_back(req_item(KIND_UNUSED, 16'd0, 32'd0));
        wait_drained();

        for (int ph = 0; ph < PHASES; ph++) begin
            c = phase_config(ph);
            apply_config(c);
            @(posedge i_clk);
            case (ph % 3)
                0: ready_mask = 16'hFFFF;
                1: ready_mask = 16'($urandom) | 16'h0001;
                default: ready_mask = 16'($urandom & $urandom) | 16'h0001;
            endcase
            repeat (ITEMS_PER_PHASE) item_backlog.push_back(make_item());
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && expected_status.size() == 0) begin
            $display("battery_and_screen_power_manager_unit regression: pass");
        end else begin
            $display("battery_and_screen_power_manager_unit regression: fail");
        end
        $finish;
    end

endmodule
`default_nettype wire

// ===== files.f =====
hdl/bpm_pkg.sv
hdl/bpm_req_if.sv
hdl/bpm_rsp_if.sv
hdl/bpm_cfg.sv
hdl/bpm_div.sv
hdl/battery_and_screen_power_manager_unit.sv
test/tb.sv
